>>> hdl/websocket_frame_encoder_defines.svh
`ifndef WEBSOCKET_FRAME_ENCODER_DEFINES_SVH
`define WEBSOCKET_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define WSFE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define WSFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/wsfe_pkg.sv
package wsfe_pkg;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  localparam logic [7:0] HDR_BIT     = 8'h80;
  localparam logic [6:0] LEN_ESC_16  = 7'd126;
  localparam logic [6:0] LEN_ESC_64  = 7'd127;
  localparam logic [62:0] LEN_SHORT_LIMIT = 63'd126;
  localparam logic [62:0] LEN_16_LIMIT    = 63'h10000;

  typedef enum logic [1:0] {
    EXT_NONE = 2'd0,
    EXT_16   = 2'd1,
    EXT_64   = 2'd2
  } ext_t;

  typedef struct packed {
    logic        func;
    logic [3:0]  opcode;
    logic [62:0] payload_length;
    logic [31:0] key_word;
    logic [7:0]  data_byte;
  } wsfe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_done;
    logic       error;
  } wsfe_out_t;

  typedef struct packed {
    logic        is_hdr;
    logic        err;
    logic        done;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic [62:0] len;
    logic [31:0] key;
    ext_t        ext;
  } wsfe_cmd_t;

  typedef struct packed {
    logic frame_open;
    logic left_zero;
  } wsfe_front_st_t;

endpackage

>>> hdl/websocket_frame_encoder.sv
// Masked client WebSocket frame encoder, one byte per result item.
// The input channel (in_valid, in_stall, in_data) takes start items, which
// carry opcode, payload length and mask key, and payload items, which carry
// one data byte. The output channel (out_valid, out_stall, out_data) gives
// the frame as a byte stream with last_of_run, frame_done and error flags.
// A start item yields 6, 8 or 14 header bytes depending on the length code;
// a payload item yields one masked byte.
// The front stage takes one item per cycle while the queue is not full and
// tracks the open frame; a queue of QUEUE_DEPTH items feeds the back stage,
// which emits one byte per cycle into an output register while unstalled.
// An accepted item is written into the queue, then its first byte into the
// output register. Payload items stream at one per cycle when unstalled; the
// header serializer sets the rate to one header byte per cycle per start.
// in_stall rises only while the queue is full.
// A stalled output holds its byte; the queue keeps accepting until full.
// Reset clears the frame state, empties the queue and drops out_valid.
`include "websocket_frame_encoder_defines.svh"

module websocket_frame_encoder
  import wsfe_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  wsfe_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output wsfe_out_t out_data
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  wsfe_cmd_t      q_cmd;
  wsfe_cmd_t      q_head;
  wsfe_front_st_t front_st;

  wsfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd),
    .status   (front_st)
  );

  wsfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  wsfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  `WSFE_ASSERT_SAME(a_open_has_bytes, clk, rst_n, front_st.frame_open, !front_st.left_zero, "open frame with no bytes left")
  `WSFE_ASSERT_SAME(a_done_is_last, clk, rst_n, out_valid && out_data.frame_done, out_data.last_of_run, "frame end inside a run")
  `WSFE_ASSERT_NEXT(a_run_continues, clk, rst_n, out_valid && !out_data.last_of_run, out_valid, "header run broken off")

endmodule

>>> hdl/wsfe_front.sv
module wsfe_front
  import wsfe_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  wsfe_in_t       in_data,
  input  logic           q_full,
  output logic           q_push,
  output wsfe_cmd_t      q_cmd,
  output wsfe_front_st_t status
);

  logic [31:0] key_store_r, key_store_nxt;
  logic [1:0]  key_phase_r, key_phase_nxt;
  logic [62:0] bytes_left_r, bytes_left_nxt;
  logic        frame_open_r, frame_open_nxt;
  logic        accept;
  logic [1:0]  kb_sel;
  logic [7:0]  key_byte;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;
  assign kb_sel   = 2'd3 - key_phase_r;
  assign key_byte = key_store_r[{kb_sel, 3'b000} +: 8];

  assign status.frame_open = frame_open_r;
  assign status.left_zero  = (bytes_left_r == '0);

  always_comb begin
    q_cmd          = '0;
    q_cmd.ext      = EXT_NONE;
    key_store_nxt  = key_store_r;
    key_phase_nxt  = key_phase_r;
    bytes_left_nxt = bytes_left_r;
    frame_open_nxt = frame_open_r;
    case (in_data.func)
      FUNC_START: begin
        q_cmd.is_hdr = 1'b1;
        q_cmd.err    = frame_open_r;
        q_cmd.done   = (in_data.payload_length == '0);
        q_cmd.opcode = in_data.opcode;
        q_cmd.len    = in_data.payload_length;
        q_cmd.key    = in_data.key_word;
        if (in_data.payload_length < LEN_SHORT_LIMIT) begin
          q_cmd.ext = EXT_NONE;
        end else if (in_data.payload_length < LEN_16_LIMIT) begin
          q_cmd.ext = EXT_16;
        end else begin
          q_cmd.ext = EXT_64;
        end
        key_store_nxt  = in_data.key_word;
        key_phase_nxt  = 2'd0;
        bytes_left_nxt = in_data.payload_length;
        frame_open_nxt = (in_data.payload_length != '0);
      end
      FUNC_DATA: begin
        if (!frame_open_r) begin
          q_cmd.err = 1'b1;
        end else begin
          q_cmd.data     = in_data.data_byte ^ key_byte;
          q_cmd.done     = (bytes_left_r == 63'd1);
          key_phase_nxt  = key_phase_r + 2'd1;
          bytes_left_nxt = bytes_left_r - 63'd1;
          frame_open_nxt = (bytes_left_r != 63'd1);
        end
      end
      default: begin
        q_cmd.err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_store_r  <= '0;
      key_phase_r  <= '0;
      bytes_left_r <= '0;
      frame_open_r <= 1'b0;
    end else if (accept) begin
      key_store_r  <= key_store_nxt;
      key_phase_r  <= key_phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      frame_open_r <= frame_open_nxt;
    end
  end

endmodule

>>> hdl/wsfe_queue.sv
module wsfe_queue
  import wsfe_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  wsfe_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output wsfe_cmd_t head
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PTR_W = $clog2(DEPTH);

  wsfe_cmd_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hdl/wsfe_back.sv
module wsfe_back
  import wsfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  wsfe_cmd_t head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output wsfe_out_t out_data
);

  logic [3:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  wsfe_out_t   out_data_r;
  wsfe_out_t   res;
  logic        load;
  logic        last;
  logic [3:0]  ext_len;
  logic [3:0]  last_idx;
  logic [3:0]  pos;
  logic [3:0]  len_pos;
  logic [3:0]  key_pos;
  logic [1:0]  key_sel;
  logic [63:0] len64;
  logic [6:0]  len_code;

  assign len64    = {1'b0, head.len};
  assign load     = head_valid && (!out_valid_r || !out_stall);
  assign pos      = idx_r - 4'd2;
  assign len_pos  = ext_len - 4'd1 - pos;
  assign key_pos  = pos - ext_len;
  assign key_sel  = 2'd3 - key_pos[1:0];
  assign last_idx = ext_len + 4'd5;

  always_comb begin
    case (head.ext)
      EXT_NONE: begin
        ext_len  = 4'd0;
        len_code = head.len[6:0];
      end
      EXT_16: begin
        ext_len  = 4'd2;
        len_code = LEN_ESC_16;
      end
      EXT_64: begin
        ext_len  = 4'd8;
        len_code = LEN_ESC_64;
      end
      default: begin
        ext_len  = 4'd0;
        len_code = head.len[6:0];
      end
    endcase
  end

  always_comb begin
    res  = '0;
    last = 1'b1;
    if (head.is_hdr) begin
      last = (idx_r == last_idx);
      if (idx_r == 4'd0) begin
        res.out_byte = HDR_BIT | {4'h0, head.opcode};
      end else if (idx_r == 4'd1) begin
        res.out_byte = HDR_BIT | {1'b0, len_code};
      end else if (pos < ext_len) begin
        res.out_byte = len64[{len_pos[2:0], 3'b000} +: 8];
      end else begin
        res.out_byte = head.key[{key_sel, 3'b000} +: 8];
      end
      res.last_of_run = last;
      res.frame_done  = last && head.done;
      res.error       = head.err;
    end else begin
      res.out_byte    = head.data;
      res.last_of_run = 1'b1;
      res.frame_done  = head.done;
      res.error       = head.err;
    end
  end

  assign pop = load && last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = last ? 4'd0 : idx_r + 4'd1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/sv/tb_websocket_frame_encoder.sv
`timescale 1ns / 1ps

module tb_websocket_frame_encoder;
  import wsfe_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 197;
  localparam int N_DIRECTED = 23;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic        func;
    logic [3:0]  opcode;
    logic [62:0] len;
    logic [31:0] key;
    logic [7:0]  data;
    logic        typed;
    wsfe_out_t   exp;
  } dir_row_t;

  typedef struct packed {
    wsfe_in_t  item;
    logic      typed;
    wsfe_out_t exp;
  } stim_row_t;

  localparam wsfe_out_t STRAY = '{out_byte: 8'h00, last_of_run: 1'b1, frame_done: 1'b0,
                                  error: 1'b1};
  localparam wsfe_out_t NONE = '0;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{FUNC_DATA,  4'h0, 63'd0,      32'h0000_0000, 8'h00, 1'b1, STRAY},
    '{FUNC_START, 4'h1, 63'd0,      32'hDEAD_BEEF, 8'h00, 1'b0, NONE},
    '{FUNC_DATA,  4'h0, 63'd0,      32'h0000_0000, 8'h5A, 1'b1, STRAY},
    '{FUNC_START, 4'hF, 63'd125,    32'hFFFF_FFFF, 8'h00, 1'b0, NONE},
    '{FUNC_DATA,  4'h0, 63'd0,      32'h0000_0000, 8'h00, 1'b0, NONE},
    '{FUNC_DATA,  4'h0, 63'd0,      32'h0000_0000, 8'hFF, 1'b0, NONE},
    '{FUNC_DATA,  4'h0, 63'd0,      32'h0000_0000, 8'hA5, 1'b0, NONE},
    '{FUNC_DATA,  4'h0, 63'd0,      32'h0000_0000, 8'h5A, 1'b0, NONE},
    '{FUNC_START, 4'h0, 63'd126,    32'h0000_0000, 8'h00, 1'b0, NONE},
    '{FUNC_DATA,  4'h0, 63'd0,      32'h0000_0000, 8'hC3, 1'b0, NONE},
    '{FUNC_START, 4'h2, 63'hFFFF,   32'h8000_0001, 8'h00, 1'b0, NONE},
    '{FUNC_START, 4'h8, 63'h10000,  32'h0123_4567, 8'h00, 1'b0, NONE},
    '{FUNC_DATA,  4'h0, 63'd0,      32'h0000_0000, 8'h01, 1'b0, NONE},
    '{FUNC_START, 4'h9, {63{1'b1}}, 32'hA5A5_A5A5, 8'h00, 1'b0, NONE},
    '{FUNC_DATA,  4'h0, 63'd0,      32'h0000_0000, 8'h80, 1'b0, NONE},
    '{FUNC_START, 4'hA, 63'd1,      32'h1234_5678, 8'h00, 1'b0, NONE},
    '{FUNC_DATA,  4'h0, 63'd0,      32'h0000_0000, 8'hFF, 1'b0, NONE},
    '{FUNC_DATA,  4'h0, 63'd0,      32'h0000_0000, 8'h00, 1'b1, STRAY},
    '{FUNC_START, 4'h1, 63'd2,      32'h0F0F_0F0F, 8'h00, 1'b0, NONE},
    '{FUNC_DATA,  4'h0, 63'd0,      32'h0000_0000, 8'h11, 1'b0, NONE},
    '{FUNC_DATA,  4'h0, 63'd0,      32'h0000_0000, 8'h22, 1'b0, NONE},
    '{FUNC_DATA,  4'h0, 63'd0,      32'h0000_0000, 8'h33, 1'b1, STRAY},
    '{FUNC_START, 4'h2, 63'd0,      32'h0000_0000, 8'h00, 1'b0, NONE}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  wsfe_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  wsfe_out_t out_data;

  websocket_frame_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stim_row_t rows[$];
  wsfe_out_t frame_bytes_due[$];

  logic [31:0] enc_key = '0;
  logic [1:0]  enc_phase = '0;
  logic [62:0] enc_left = '0;
  logic        enc_open = 1'b0;

  int next_row = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int src_idle_pct = 20;
  int sink_idle_pct = 20;
  int cycles = 0;
  int fail_cnt = 0;
  int checked_cnt = 0;
  int frame_cnt = 0;
  int cut_cnt = 0;
  int payload_cnt = 0;
  int stray_cnt = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic wsfe_in_t make_start(logic [3:0] op, logic [62:0] len, logic [31:0] key);
    wsfe_in_t it;
    it.func = FUNC_START;
    it.opcode = op;
    it.payload_length = len;
    it.key_word = key;
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  function automatic wsfe_in_t make_data(logic [7:0] b);
    wsfe_in_t it;
    logic [63:0] w;
    w = {$urandom, $urandom};
    it.func = FUNC_DATA;
    it.opcode = 4'($urandom);
    it.payload_length = w[62:0];
    it.key_word = $urandom;
    it.data_byte = b;
    return it;
  endfunction

  function automatic void encode_item(input wsfe_in_t it);
    logic [7:0] hdr [14];
    int n;
    int nb;
    logic err;
    logic [7:0] kb;
    logic done;
    n = 0;
    if (it.func == FUNC_START) begin
      err = enc_open;
      hdr[n] = HDR_BIT | {4'h0, it.opcode};
      n++;
      if (it.payload_length < LEN_SHORT_LIMIT) begin
        hdr[n] = HDR_BIT | it.payload_length[7:0];
        nb = 0;
      end else if (it.payload_length < LEN_16_LIMIT) begin
        hdr[n] = HDR_BIT | {1'b0, LEN_ESC_16};
        nb = 2;
      end else begin
        hdr[n] = HDR_BIT | {1'b0, LEN_ESC_64};
        nb = 8;
      end
      n++;
      for (int i = nb - 1; i >= 0; i--) begin
        hdr[n] = 8'(it.payload_length >> (8 * i));
        n++;
      end
      for (int i = 3; i >= 0; i--) begin
        hdr[n] = 8'(it.key_word >> (8 * i));
        n++;
      end
      for (int i = 0; i < n; i++) begin
        frame_bytes_due.push_back('{out_byte: hdr[i], last_of_run: (i == n - 1),
                                    frame_done: (i == n - 1) && (it.payload_length == 0),
                                    error: err});
      end
      enc_key = it.key_word;
      enc_phase = '0;
      enc_left = it.payload_length;
      enc_open = (it.payload_length != 0);
    end else if (!enc_open || enc_left == 0) begin
      frame_bytes_due.push_back(STRAY);
    end else begin
      kb = 8'(enc_key >> (8 * (3 - enc_phase)));
      enc_phase = enc_phase + 2'd1;
      enc_left = enc_left - 63'd1;
      done = (enc_left == 0);
      if (done) enc_open = 1'b0;
      frame_bytes_due.push_back('{out_byte: it.data_byte ^ kb, last_of_run: 1'b1,
                                  frame_done: done, error: 1'b0});
    end
  endfunction

  function automatic void expect_item(input stim_row_t row);
    int n0;
    n0 = frame_bytes_due.size();
    if (row.item.func == FUNC_START) begin
      frame_cnt++;
      if (enc_open) cut_cnt++;
    end else if (enc_open) begin
      payload_cnt++;
    end else begin
      stray_cnt++;
    end
    encode_item(row.item);
    if (row.typed) begin
      while (frame_bytes_due.size() > n0) frame_bytes_due.pop_back();
      frame_bytes_due.push_back(row.exp);
    end
  endfunction

  function automatic void check_byte(input wsfe_out_t got);
    wsfe_out_t want;
    logic bad;
    checked_cnt++;
    if (frame_bytes_due.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS) begin
        $display("[%0d] unexpected result: byte=%02h last=%0b done=%0b err=%0b", cycles,
                 got.out_byte, got.last_of_run, got.frame_done, got.error);
      end
      return;
    end
    want = frame_bytes_due.pop_front();
    bad = (got.out_byte !== want.out_byte) || (got.last_of_run !== want.last_of_run) ||
          (got.frame_done !== want.frame_done) || (got.error !== want.error);
    if (bad) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS) begin
        $display("[%0d] mismatch: expected byte=%02h last=%0b done=%0b err=%0b", cycles,
                 want.out_byte, want.last_of_run, want.frame_done, want.error);
        $display("[%0d]           actual   byte=%02h last=%0b done=%0b err=%0b", cycles,
                 got.out_byte, got.last_of_run, got.frame_done, got.error);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (!(in_valid && in_stall)) begin
        if (in_valid) begin
          expect_item(rows[next_row]);
          next_row++;
        end
        if (src_gap == 0 && $urandom_range(0, 99) < src_idle_pct) src_gap = pick_gap();
        if (src_gap > 0 || next_row >= rows.size()) begin
          in_valid <= 1'b0;
          if (src_gap > 0) src_gap--;
        end else begin
          in_valid <= 1'b1;
          in_data <= rows[next_row].item;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_byte(out_data);
      if (sink_gap == 0 && $urandom_range(0, 99) < sink_idle_pct) sink_gap = pick_gap();
      if (sink_gap > 0) begin
        out_stall <= 1'b1;
        sink_gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles % 400 == 0) begin
      src_idle_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      sink_idle_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles,
               frame_bytes_due.size());
      $display("tb_websocket_frame_encoder NOT OK");
      $finish;
    end
  end

  initial begin
    dir_row_t d;
    wsfe_in_t it;
    logic [62:0] len;
    logic [63:0] w;
    int target;
    int r;
    int k;

    for (int i = 0; i < N_DIRECTED; i++) begin
      d = DIRECTED[i];
      if (d.func == FUNC_START) it = make_start(d.opcode, d.len, d.key);
      else it = make_data(d.data);
      rows.push_back('{item: it, typed: d.typed, exp: d.exp});
    end

    target = rows.size() + RANDOM_ITEMS;
    while (rows.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        w = {$urandom, $urandom};
        it = {w[0], 4'($urandom), w[63:1], 32'($urandom), 8'($urandom)};
        rows.push_back('{item: it, typed: 1'b0, exp: NONE});
      end else begin
        r = $urandom_range(0, 99);
        w = {$urandom, $urandom};
        if (r < 40) len = 63'($urandom_range(0, 12));
        else if (r < 55) len = 63'($urandom_range(13, 40));
        else if (r < 70) len = 63'($urandom_range(120, 131));
        else if (r < 80) len = 63'($urandom_range(65530, 65541));
        else if (r < 90) len = 63'($urandom_range(126, 65535));
        else len = w[62:0];
        rows.push_back('{item: make_start(4'($urandom), len, $urandom), typed: 1'b0,
                         exp: NONE});
        if (len <= 40) begin
          k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, int'(len)) : int'(len);
          if (k == int'(len) && $urandom_range(0, 9) == 0) k = k + $urandom_range(1, 2);
        end else begin
          k = $urandom_range(0, 6);
        end
        for (int j = 0; j < k; j++) begin
          rows.push_back('{item: make_data(8'($urandom)), typed: 1'b0, exp: NONE});
        end
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (next_row < rows.size()) @(posedge clk);
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d frame starts (%0d cutting a frame short), %0d payload bytes,",
             rows.size(), frame_cnt, cut_cnt, payload_cnt);
    $display("%0d stray payload items; %0d result bytes checked, %0d failures.",
             stray_cnt, checked_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb_websocket_frame_encoder OK");
    end else begin
      $display("tb_websocket_frame_encoder NOT OK");
    end
    $finish;
  end

endmodule
